>>> hdl/positional_list_engine_macros.svh
// Assertion helpers used by the top-level engine, the only file that carries checks.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PLE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

>>> hdl/ple_pkg.sv
package ple_pkg;

   localparam logic [2:0] KIND_GET    = 3'd0;
   localparam logic [2:0] KIND_HEAD   = 3'd1;
   localparam logic [2:0] KIND_TAIL   = 3'd2;
   localparam logic [2:0] KIND_INDEX  = 3'd3;
   localparam logic [2:0] KIND_DELETE = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      RV_ZERO,
      RV_ONES,
      RV_READ
   } rv_sel_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       set_result;
      rv_sel_type rv_sel;
      logic [1:0] st_code;
      logic       ins_setup;
      logic       del_setup;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_shift;
      logic       wr_value;
      logic       idx_dec;
      logic       idx_inc;
      logic       count_inc;
      logic       count_dec;
      logic       post;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       pos_lt_count;
      logic       full;
      logic       idx_gt_tgt;
      logic       idx_next_lt_count;
      logic       rsp_free;
   } dp_status_type;

endpackage

>>> hdl/positional_list_engine.sv
// Channel   Direction  tdata                                  tuser
// req_      in         position[7:0], value_in[39:8]          kind[2:0]
// rsp_      out        read_value[31:0], item_count[36:32]    status[1:0]
//
// An insert before slot p moves each entry from slot p to the end up one slot, and a delete
// moves each entry after the deleted position down one slot.
// The entry shift loop moves one entry at a time through the RAM ports, a read then a write.
// Reset is synchronous and empties the list; entries need no clearing pass.
// A finished result waits in the output register while the next request beat is taken;
// only the final step of that next beat stalls until the output register is free.
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[7:0], value_in[39:8]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[31:0], item_count[36:32], zero[39:37]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   ple_pkg::ctrl_cmd_type  cmd;
   ple_pkg::dp_status_type status;

   logic signed [ple_pkg::VALUE_W-1:0] rsp_read_value;
   logic [4:0]                         rsp_item_count;
   logic                               rsp_full_beat;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ple_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_tuser),
      .req_position   (req_tdata[7:0]),
      .req_value_in   (req_tdata[39:8]),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_tuser),
      .rsp_item_count (rsp_item_count)
   );

   assign rsp_tdata = {3'b000, rsp_item_count, rsp_read_value};

   assign rsp_full_beat = rsp_tvalid && (rsp_tuser == ple_pkg::STATUS_FULL);

   `PLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `PLE_ASSERT_IMP(a_reopen, clock, reset, $rose(rsp_tvalid), req_tready && $past(!req_tready))
   `PLE_ASSERT_IMP(a_full_reads_zero, clock, reset, rsp_full_beat, rsp_tdata[31:0] == 32'd0)

endmodule

>>> hdl/ple_ram.sv
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ple_ctrl.sv
module ple_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ple_pkg::dp_status_type status,
   output ple_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_GET_WAIT,
      S_INS_CHECK,
      S_INS_MOVE,
      S_DEL_CHECK,
      S_DEL_MOVE,
      S_POST
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_result = 1'b1;
            cmd.rv_sel     = ple_pkg::RV_ZERO;
            cmd.st_code    = ple_pkg::STATUS_DONE;
            case (status.kind)
               ple_pkg::KIND_GET: begin
                  if (status.pos_lt_count) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = ple_pkg::RD_POS;
                     state_in   = S_GET_WAIT;
                  end else begin
                     cmd.rv_sel  = ple_pkg::RV_ONES;
                     cmd.st_code = ple_pkg::STATUS_RANGE;
                     state_in    = S_POST;
                  end
               end
               ple_pkg::KIND_HEAD, ple_pkg::KIND_TAIL, ple_pkg::KIND_INDEX: begin
                  if (status.full) begin
                     cmd.st_code = ple_pkg::STATUS_FULL;
                     state_in    = S_POST;
                  end else begin
                     cmd.ins_setup = 1'b1;
                     state_in      = S_INS_CHECK;
                  end
               end
               ple_pkg::KIND_DELETE: begin
                  if (status.pos_lt_count) begin
                     cmd.del_setup = 1'b1;
                     state_in      = S_DEL_CHECK;
                  end else begin
                     cmd.st_code = ple_pkg::STATUS_RANGE;
                     state_in    = S_POST;
                  end
               end
               default: begin
                  cmd.st_code = ple_pkg::STATUS_RANGE;
                  state_in    = S_POST;
               end
            endcase
         end
         S_GET_WAIT: begin
            cmd.set_result = 1'b1;
            cmd.rv_sel     = ple_pkg::RV_READ;
            cmd.st_code    = ple_pkg::STATUS_DONE;
            state_in       = S_POST;
         end
         S_INS_CHECK: begin
            if (status.idx_gt_tgt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ple_pkg::RD_PREV;
               state_in   = S_INS_MOVE;
            end else begin
               cmd.wr_value  = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_POST;
            end
         end
         S_INS_MOVE: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = S_INS_CHECK;
         end
         S_DEL_CHECK: begin
            if (status.idx_next_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ple_pkg::RD_NEXT;
               state_in   = S_DEL_MOVE;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_POST;
            end
         end
         S_DEL_MOVE: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_DEL_CHECK;
         end
         S_POST: begin
            if (status.rsp_free) begin
               cmd.post = 1'b1;
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            ready_in = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

>>> hdl/ple_datapath.sv
module ple_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [2:0]                     req_kind,
   input  logic [7:0]                     req_position,
   input  logic signed [ple_pkg::VALUE_W-1:0] req_value_in,
   input  ple_pkg::ctrl_cmd_type          cmd,
   output ple_pkg::dp_status_type         status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [ple_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [1:0]                     rsp_status,
   output logic [4:0]                     rsp_item_count
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int PW = (CW > 8) ? CW : 8;
   localparam int VW = ple_pkg::VALUE_W;

   logic [2:0]    kind_ff;
   logic [7:0]    pos_ff;
   logic [VW-1:0] val_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] tgt_ff, tgt_in;
   logic [VW-1:0] rv_ff;
   logic [1:0]    st_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff;
   logic [1:0]    rsp_status_ff;
   logic [4:0]    rsp_count_ff;

   logic [PW-1:0] pos_w, cnt_w;
   logic [CW-1:0] pos_clamp;
   logic [CW-1:0] idx_prev, idx_next;
   logic [CW+4:0] count_x;
   logic [AW-1:0] rd_addr;
   logic [VW-1:0] ram_rdata;
   logic [VW-1:0] rv_next;
   logic          wr_en;

   assign pos_w     = PW'(pos_ff);
   assign cnt_w     = PW'(count_ff);
   assign pos_clamp = (pos_w > cnt_w) ? count_ff : pos_w[CW-1:0];
   assign idx_prev  = idx_ff - CW'(1);
   assign idx_next  = idx_ff + CW'(1);
   assign count_x   = (CW + 5)'(count_ff);

   assign status.kind              = kind_ff;
   assign status.pos_lt_count      = pos_w < cnt_w;
   assign status.full              = count_ff == CW'(DEPTH);
   assign status.idx_gt_tgt        = idx_ff > tgt_ff;
   assign status.idx_next_lt_count = idx_next < count_ff;
   assign status.rsp_free          = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.rd_sel)
         ple_pkg::RD_POS:  rd_addr = pos_w[AW-1:0];
         ple_pkg::RD_PREV: rd_addr = idx_prev[AW-1:0];
         ple_pkg::RD_NEXT: rd_addr = idx_next[AW-1:0];
         default:          rd_addr = pos_w[AW-1:0];
      endcase
   end

   assign wr_en = cmd.wr_shift || cmd.wr_value;

   ple_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (cmd.wr_value ? val_ff : ram_rdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      case (cmd.rv_sel)
         ple_pkg::RV_ZERO: rv_next = '0;
         ple_pkg::RV_ONES: rv_next = '1;
         ple_pkg::RV_READ: rv_next = ram_rdata;
         default:          rv_next = '0;
      endcase
   end

   always_comb begin
      tgt_in = tgt_ff;
      idx_in = idx_ff;
      if (cmd.ins_setup) begin
         idx_in = count_ff;
         case (kind_ff)
            ple_pkg::KIND_HEAD: tgt_in = '0;
            ple_pkg::KIND_TAIL: tgt_in = count_ff;
            default:            tgt_in = pos_clamp;
         endcase
      end else if (cmd.del_setup) begin
         idx_in = pos_w[CW-1:0];
      end else if (cmd.idx_dec) begin
         idx_in = idx_prev;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      if (cmd.load) begin
         kind_ff <= req_kind;
         pos_ff  <= req_position;
         val_ff  <= req_value_in;
      end
      if (cmd.set_result) begin
         rv_ff <= rv_next;
         st_ff <= cmd.st_code;
      end
      if (cmd.post) begin
         rsp_value_ff  <= rv_ff;
         rsp_status_ff <= st_ff;
         rsp_count_ff  <= count_x[4:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_count = rsp_count_ff;

endmodule

>>> test/tb_positional_list_engine.sv
module tb_positional_list_engine;

   localparam int LIST_DEPTH     = 16;
   localparam int ITEMS_PER_LAP  = 150;
   localparam int LAPS           = 13;
   localparam int QUIET_ITEMS    = 200;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 60;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [31:0] read_value;
      logic [1:0]  status;
      logic [4:0]  item_count;
   } list_reply_type;

   class list_scoreboard;
      logic [31:0] shadow_list[$];
      list_reply_type replies_due[$];
      int unsigned errors;

      function void note_request(logic [2:0] kind, logic [7:0] pos, logic [31:0] value);
         list_reply_type reply;
         int unsigned slot;
         int unsigned fill;
         fill = shadow_list.size();
         reply.read_value = '0;
         reply.status = ple_pkg::STATUS_DONE;
         case (kind)
            ple_pkg::KIND_GET: begin
               if (pos < fill) begin
                  reply.read_value = shadow_list[pos];
               end else begin
                  reply.read_value = '1;
                  reply.status = ple_pkg::STATUS_RANGE;
               end
            end
            ple_pkg::KIND_HEAD, ple_pkg::KIND_TAIL, ple_pkg::KIND_INDEX: begin
               if (fill >= LIST_DEPTH) begin
                  reply.status = ple_pkg::STATUS_FULL;
               end else begin
                  if (kind == ple_pkg::KIND_HEAD) slot = 0;
                  else if (kind == ple_pkg::KIND_TAIL) slot = fill;
                  else slot = (pos > fill) ? fill : pos;
                  shadow_list.insert(slot, value);
               end
            end
            ple_pkg::KIND_DELETE: begin
               if (pos < fill) shadow_list.delete(pos);
               else reply.status = ple_pkg::STATUS_RANGE;
            end
            default: begin
               reply.status = ple_pkg::STATUS_RANGE;
            end
         endcase
         reply.item_count = 5'(shadow_list.size());
         replies_due.push_back(reply);
      endfunction

      function void check_response(logic [39:0] data, logic [1:0] status);
         list_reply_type want;
         if (replies_due.size() == 0) begin
            $error("response beat with no request outstanding: tdata %h status %0d",
                   data, status);
            errors++;
         end else begin
            want = replies_due.pop_front();
            if (data[31:0] !== want.read_value) begin
               $error("read_value: expected %h, actual %h", want.read_value, data[31:0]);
               errors++;
            end
            if (status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, status);
               errors++;
            end
            if (data[36:32] !== want.item_count) begin
               $error("item_count: expected %0d, actual %0d", want.item_count, data[36:32]);
               errors++;
            end
            if (data[39:37] !== 3'b000) begin
               $error("tdata padding: expected 0, actual %b", data[39:37]);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position[7:0], value_in[39:8]
   logic [2:0]  req_tuser = '0;   // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // read_value[31:0], item_count[36:32], zero[39:37]
   logic [1:0]  rsp_tuser;       // status[1:0]

   list_scoreboard shadow = new();
   bit quiet_phase = 1'b0;
   bit hold_off_request = 1'b0;
   int unsigned stalled_cycles = 0;

   positional_list_engine #(.DEPTH(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         shadow.note_request(req_tuser, req_tdata[7:0], req_tdata[39:8]);
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.check_response(rsp_tdata, rsp_tuser);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL positional_list_engine");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input logic [2:0] kind, input logic [7:0] pos,
                            input logic [31:0] value);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {value, pos};
      do @(posedge clock); while (!req_tready);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (shadow.replies_due.size() != 0);
   endtask

   task automatic send_random_op(input int insert_weight);
      logic [2:0]  kind;
      logic [7:0]  pos;
      int unsigned roll;
      int unsigned fill;
      fill = shadow.shadow_list.size();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         kind = ple_pkg::KIND_DELETE + 3'($urandom_range(1, 3));
      end else if (roll < 18) begin
         kind = ple_pkg::KIND_GET;
      end else if (roll < 18 + insert_weight) begin
         case ($urandom_range(0, 2))
            0: kind = ple_pkg::KIND_HEAD;
            1: kind = ple_pkg::KIND_TAIL;
            default: kind = ple_pkg::KIND_INDEX;
         endcase
      end else begin
         kind = ple_pkg::KIND_DELETE;
      end
      if ($urandom_range(0, 9) == 0) pos = 8'($urandom);
      else pos = 8'($urandom_range(0, fill + 1));
      send_beat(kind, pos, $urandom);
   endtask

   initial begin
      int insert_weight;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_beat(ple_pkg::KIND_GET, 8'd0, 32'h0);
      send_beat(ple_pkg::KIND_DELETE, 8'd0, 32'h0);
      send_beat(ple_pkg::KIND_INDEX, 8'd255, 32'h1234_5678);
      send_beat(ple_pkg::KIND_HEAD, 8'd0, 32'h8000_0000);
      send_beat(ple_pkg::KIND_TAIL, 8'd0, 32'h7fff_ffff);
      send_beat(ple_pkg::KIND_INDEX, 8'd0, 32'hffff_ffff);
      send_beat(ple_pkg::KIND_INDEX, 8'd2, 32'h0000_0000);
      send_beat(ple_pkg::KIND_GET, 8'd0, 32'h0);
      send_beat(ple_pkg::KIND_GET, 8'd4, 32'h0);
      send_beat(ple_pkg::KIND_GET, 8'd5, 32'h0);
      send_beat(ple_pkg::KIND_GET, 8'd255, 32'hffff_ffff);
      send_beat(ple_pkg::KIND_DELETE, 8'd5, 32'h0);
      send_beat(ple_pkg::KIND_DELETE, 8'd255, 32'h0);
      send_beat(ple_pkg::KIND_DELETE + 3'd1, 8'd255, 32'hffff_ffff);
      send_beat(ple_pkg::KIND_DELETE + 3'd2, 8'd0, 32'h0);
      send_beat(ple_pkg::KIND_DELETE + 3'd3, 8'd1, 32'h1);
      send_beat(ple_pkg::KIND_DELETE, 8'd4, 32'h0);
      send_beat(ple_pkg::KIND_DELETE, 8'd0, 32'h0);
      send_beat(ple_pkg::KIND_DELETE, 8'd1, 32'h0);
      send_beat(ple_pkg::KIND_INDEX, 8'd1, 32'h5555_5555);
      send_beat(ple_pkg::KIND_INDEX, 8'd3, 32'haaaa_aaaa);
      send_beat(ple_pkg::KIND_GET, 8'd1, 32'h0);
      send_beat(ple_pkg::KIND_GET, 8'd3, 32'h0);

      for (int lap = 0; lap < LAPS; lap++) begin
         case (lap % 3)
            0: insert_weight = 70;
            1: insert_weight = 40;
            default: insert_weight = 20;
         endcase
         for (int n = 0; n < ITEMS_PER_LAP; n++) begin
            if (lap == 4 && n == 0) hold_off_request = 1'b1;
            if (lap == 8 && n == 0) wait_for_replies();
            if (lap * ITEMS_PER_LAP + n >= LAPS * ITEMS_PER_LAP - QUIET_ITEMS)
               quiet_phase = 1'b1;
            send_random_op(insert_weight);
         end
      end

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.errors == 0 && shadow.replies_due.size() == 0)
         $display("PASS positional_list_engine");
      else
         $display("FAIL positional_list_engine");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_ram.sv
hdl/ple_ctrl.sv
hdl/ple_datapath.sv
hdl/positional_list_engine.sv
test/tb_positional_list_engine.sv
